[rtl/core/u8u16_pkg.sv]
// Package for the UTF-8 to UTF-16 transcoder: payload types, state type and constants.
package u8u16_pkg;

  localparam int unsigned COUNT_WIDTH_DEFAULT = 16;
  localparam logic [15:0] CAPACITY_RESET      = 16'd1024;
  localparam int unsigned MAX_RESULTS         = 3;

  // Summary status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_PARTIAL = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  localparam logic [15:0] HIGH_SURROGATE = 16'hD800;
  localparam logic [15:0] LOW_SURROGATE  = 16'hDC00;
  localparam logic [20:0] PLANE_OFFSET   = 21'h10000;
  localparam logic [15:0] REPORT_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        is_summary;
    logic        last;
    logic [15:0] written_units;
    logic [15:0] needed_units;
    logic [1:0]  status;
  } out_t;

  // Sequence state that does not depend on the counter width
  typedef struct packed {
    logic [1:0]  pending;
    logic [20:0] acc;
    logic        stopped;
  } seq_state_t;

endpackage

[rtl/core/u8u16_step.sv]
// Combinational step: decodes one byte against the current state into up to three results.
module u8u16_step import u8u16_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  in_t                    in_data,
  input  seq_state_t             seq_cur,
  input  logic [COUNT_WIDTH-1:0] written_cur,
  input  logic [COUNT_WIDTH-1:0] needed_cur,
  input  logic [15:0]            capacity,
  output seq_state_t             seq_nxt,
  output logic [COUNT_WIDTH-1:0] written_nxt,
  output logic [COUNT_WIDTH-1:0] needed_nxt,
  output out_t                   items [MAX_RESULTS],
  output logic [1:0]             item_count
);

  localparam int unsigned CMPW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 2;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                     input logic [1:0] b);
    logic [COUNT_WIDTH:0] s;
    begin
      s = {1'b0, a} + (COUNT_WIDTH+1)'(b);
      sat_add = s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
    end
  endfunction

  function automatic logic [15:0] report16(input logic [COUNT_WIDTH-1:0] v);
    logic [CMPW-1:0] ev;
    begin
      ev = CMPW'(v);
      report16 = (ev > CMPW'(REPORT_MAX)) ? REPORT_MAX : ev[15:0];
    end
  endfunction

  always_comb begin
    logic [1:0]      pend;
    logic [20:0]     acc;
    logic            emit;
    logic [20:0]     cp;
    logic [20:0]     v;
    logic            pair;
    logic            fits;
    logic            ok;
    logic            stopped;
    logic [CMPW-1:0] room;
    logic [CMPW-1:0] wr_ext;
    logic [1:0]      units;
    logic [1:0]      total;
    logic [1:0]      status;
    logic [15:0]     hi_unit;
    logic [15:0]     lo_unit;
    logic [COUNT_WIDTH-1:0] wr;
    logic [COUNT_WIDTH-1:0] nd;

    pend = seq_cur.pending;
    acc  = seq_cur.acc;
    emit = 1'b0;
    cp   = '0;

    if (seq_cur.pending == 2'd0) begin
      priority if (in_data.byte_in[7:4] <= 4'hB) begin
        emit = 1'b1;
        cp   = 21'(in_data.byte_in);
      end else if (in_data.byte_in[7:4] <= 4'hD) begin
        acc  = 21'(in_data.byte_in[4:0]);
        pend = 2'd1;
      end else if (in_data.byte_in[7:4] == 4'hE) begin
        acc  = 21'(in_data.byte_in[3:0]);
        pend = 2'd2;
      end else begin
        acc  = 21'(in_data.byte_in[2:0]);
        pend = 2'd3;
      end
    end else begin
      acc  = {seq_cur.acc[14:0], in_data.byte_in[5:0]};
      pend = seq_cur.pending - 2'd1;
      emit = (pend == 2'd0);
      cp   = acc;
    end

    // Room is capacity minus the reserved slot
    room   = (capacity == 16'd0) ? '0 : CMPW'(capacity) - CMPW'(1);
    wr_ext = CMPW'(written_cur);
    pair   = |cp[20:16];
    fits   = pair ? (wr_ext + CMPW'(2) <= room) : (wr_ext < room);
    ok     = emit && !seq_cur.stopped && fits;
    stopped = seq_cur.stopped | (emit & ~ok);

    nd = emit ? sat_add(needed_cur, pair ? 2'd2 : 2'd1) : needed_cur;
    wr = ok ? sat_add(written_cur, pair ? 2'd2 : 2'd1) : written_cur;

    v       = cp - PLANE_OFFSET;
    hi_unit = 16'(v[20:10]) + HIGH_SURROGATE;
    lo_unit = {6'd0, v[9:0]} + LOW_SURROGATE;

    units  = ok ? (pair ? 2'd2 : 2'd1) : 2'd0;
    total  = units + {1'b0, in_data.last_byte};
    status = (pend != 2'd0) ? STATUS_PARTIAL : (stopped ? STATUS_FULL : STATUS_OK);

    for (int i = 0; i < MAX_RESULTS; i++) begin
      items[i] = '0;
      if (2'(i) < units) begin
        items[i].unit = (i == 0) ? (pair ? hi_unit : cp[15:0]) : lo_unit;
      end else if (2'(i) == units) begin
        items[i].is_summary    = 1'b1;
        items[i].written_units = report16(wr);
        items[i].needed_units  = report16(nd);
        items[i].status        = status;
      end
      items[i].last = (2'(i) + 2'd1 == total);
    end
    item_count = total;

    if (in_data.last_byte) begin
      seq_nxt     = '0;
      written_nxt = '0;
      needed_nxt  = '0;
    end else begin
      seq_nxt.pending = pend;
      seq_nxt.acc     = acc;
      seq_nxt.stopped = stopped;
      written_nxt     = wr;
      needed_nxt      = nd;
    end
  end

endmodule

[rtl/core/utf8_to_utf16_transcoder.sv]
// Top level of the UTF-8 to UTF-16 transcoder: state, capacity register and result buffer.
//
//   Channel | Handshake          | Beat
//   --------+--------------------+-----------------------------------------------
//   in_     | in_valid/in_stall  | one UTF-8 byte and its end-of-string flag
//   out_    | out_valid/out_stall| one UTF-16 unit or one end-of-string summary
//   cfg_    | cfg_valid/cfg_ready| output capacity in units (always ready)
//
// A byte is decoded in the cycle it is accepted and its results are in the
// result buffer on the next cycle. One result leaves per cycle while out_stall
// is low. A byte causes one result per unit it emits (two for a surrogate pair),
// plus one summary on its end-of-string flag; the result buffer holds three.
// Synchronous reset clears the sequence state, the counters and the buffer count
// (not the buffer payload) and restores the capacity to 1024. A result-side stall
// holds the buffer; a new byte enters once it is empty or its last entry leaves.
module utf8_to_utf16_transcoder import u8u16_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0]            capacity_r;
  seq_state_t             seq_r, seq_nxt;
  logic [COUNT_WIDTH-1:0] written_r, written_nxt;
  logic [COUNT_WIDTH-1:0] needed_r, needed_nxt;
  out_t                   buf_r [MAX_RESULTS];
  logic [1:0]             cnt_r;
  out_t                   items [MAX_RESULTS];
  logic [1:0]             item_count;
  logic                   in_take;
  logic                   out_take;

  // The capacity register takes every write; the user is to write it only while idle, the block does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else if (cfg_valid) begin
      capacity_r <= cfg_data;
    end
  end

  u8u16_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .in_data     (in_data),
    .seq_cur     (seq_r),
    .written_cur (written_r),
    .needed_cur  (needed_r),
    .capacity    (capacity_r),
    .seq_nxt     (seq_nxt),
    .written_nxt (written_nxt),
    .needed_nxt  (needed_nxt),
    .items       (items),
    .item_count  (item_count)
  );

  // The head of the buffer is the result on offer.
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = buf_r[0];
  assign out_take  = out_valid && !out_stall;

  // A new byte may enter once the buffer is empty or its last entry leaves now.
  assign in_stall = !((cnt_r == 2'd0) || ((cnt_r == 2'd1) && !out_stall));
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= '0;
      written_r <= '0;
      needed_r  <= '0;
      cnt_r     <= 2'd0;
    end else if (in_take) begin
      seq_r     <= seq_nxt;
      written_r <= written_nxt;
      needed_r  <= needed_nxt;
      cnt_r     <= item_count;
    end else if (out_take) begin
      cnt_r     <= cnt_r - 2'd1;
    end
  end

  // Payload of the buffer: loaded whole on a new byte, shifted on each beat out.
  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        buf_r[i] <= items[i];
      end
    end else if (out_take) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

endmodule
